### sv/scfl_pkg.sv
// Shared types, constants and helper functions of the size-class free-list allocator.
package scfl_pkg;

  localparam int ARENA_BYTES = 1048576;
  localparam int CLASS_COUNT = 32;
  localparam int BLOCK_ALIGN = 64;
  localparam int MIN_CLASS   = 6;
  localparam int BUMP_BASE   = 448;

  localparam int ARENA_WORDS = ARENA_BYTES / 8;
  localparam int WADDR_W     = $clog2(ARENA_WORDS);
  localparam int WORD_W      = 64;
  localparam int CLS_W       = $clog2(CLASS_COUNT);
  localparam int BLK_SH      = $clog2(BLOCK_ALIGN);
  localparam int CNT_W       = 6;

  localparam int SIZE_W  = 31;
  localparam int ALIGN_W = 8;
  localparam int ADDR_W  = 21;
  localparam int CAP_W   = 21;
  localparam int HEAD_W  = 20;
  localparam int PAY_W   = 20;
  localparam int ST_W    = 3;

  localparam logic [31:0]      HDR_MAGIC = 32'hA7E4A7E4;
  localparam logic [CAP_W-1:0] CAP_RESET = 21'd1048576;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_ALIGN = 3'd1;
  localparam logic [ST_W-1:0] ST_TOO_LARGE = 3'd2;
  localparam logic [ST_W-1:0] ST_EXHAUSTED = 3'd3;
  localparam logic [ST_W-1:0] ST_FOREIGN   = 3'd4;
  localparam logic [ST_W-1:0] ST_CORRUPT   = 3'd5;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
  localparam logic [OP_W-1:0] OP_CLEAR     = 4'd1;
  localparam logic [OP_W-1:0] OP_CAPTURE   = 4'd2;
  localparam logic [OP_W-1:0] OP_POP_RD    = 4'd3;
  localparam logic [OP_W-1:0] OP_POP_UPD   = 4'd4;
  localparam logic [OP_W-1:0] OP_BUMP      = 4'd5;
  localparam logic [OP_W-1:0] OP_WR_HDR0   = 4'd6;
  localparam logic [OP_W-1:0] OP_WR_HDR1   = 4'd7;
  localparam logic [OP_W-1:0] OP_RD_W1     = 4'd8;
  localparam logic [OP_W-1:0] OP_RD_W0     = 4'd9;
  localparam logic [OP_W-1:0] OP_LATCH_HDR = 4'd10;
  localparam logic [OP_W-1:0] OP_FWR1      = 4'd11;
  localparam logic [OP_W-1:0] OP_FWR0      = 4'd12;

  typedef struct packed {
    logic               command;
    logic [SIZE_W-1:0]  request_size;
    logic [ALIGN_W-1:0] request_alignment;
    logic [ADDR_W-1:0]  release_address;
  } scfl_req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [PAY_W-1:0] payload_address;
    logic [CAP_W-1:0] live_bytes;
    logic [CAP_W-1:0] used_bytes;
  } scfl_rsp_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            out_load;
    logic [ST_W-1:0] status;
    logic            give_addr;
  } scfl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic align_bad;
    logic too_large;
    logic head_nz;
    logic bump_fits;
    logic addr_null;
    logic addr_bad;
    logic magic_ok;
    logic hdr_ok;
    logic out_free;
  } scfl_stat_t;

  function automatic logic [CNT_W-1:0] bit_len(input logic [31:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = CNT_W'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [WADDR_W-1:0] word_index(input logic [ADDR_W-1:0] b);
    return b[WADDR_W+2:3];
  endfunction

endpackage

### sv/size_class_free_list_allocator.sv
// Top level of the size-class free-list allocator: controller and datapath.
//
// Requests enter on in_valid/in_stall/in_req: command 0 allocates request_size bytes
// with request_alignment, command 1 frees release_address. Each request gives one
// result on out_valid/out_stall/out_rsp with a status, the granted payload offset
// and the live and used byte counts after the request.
// The arena_capacity register is written through cfg_valid/cfg_ready/cfg_data,
// which is always ready; write it only while no request is in progress.
// One request is handled at a time, each step making at most one access to the
// single-port arena RAM. An early error or a null free goes straight to its result;
// an allocate pops the head of its class list (read, then update) or takes the bump
// pointer, then writes the two header words; a free reads the two header words and,
// if they are sound, writes two words back and pushes the block onto its list.
// After reset the block clears all 131072 arena words one word per cycle, with
// in_stall held high; configuration writes are taken during that pass.
// A result that the receiver stalls is held in the output register; the next
// request is still accepted and runs until its own result is ready to load.
module size_class_free_list_allocator import scfl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  scfl_req_t        in_req,
  output logic             out_valid,
  input  logic             out_stall,
  output scfl_rsp_t        out_rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  scfl_cmd_t  cmd;
  scfl_stat_t stat;

  scfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  scfl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

endmodule

### sv/scfl_ram.sv
// Generic single-port RAM with registered read data.
module scfl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/scfl_dp.sv
// Datapath of the allocator: request registers, class heads, counters, arena RAM and result.
module scfl_dp import scfl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  scfl_req_t        in_req,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data,
  input  scfl_cmd_t        cmd,
  output scfl_stat_t       stat,
  output logic             out_valid,
  input  logic             out_stall,
  output scfl_rsp_t        out_rsp
);

  scfl_req_t            req_r;
  logic [CLS_W-1:0]     cls_r;
  logic                 big_r;
  logic                 off64_r;
  logic                 align_bad_r;
  logic [HEAD_W-1:0]    blk_r;
  logic [31:0]          w1hi_r;
  scfl_rsp_t            rsp_r;
  logic                 out_valid_r;

  logic [WADDR_W-1:0]   clr_r;
  logic [HEAD_W-1:0]    heads_r [CLASS_COUNT];
  logic [CAP_W-1:0]     bump_r;
  logic [CAP_W-1:0]     live_r;
  logic [CAP_W-1:0]     cap_r;

  logic [31:0]          t_size;
  logic [CNT_W-1:0]     t_len;
  logic [CNT_W-1:0]     new_cls;
  logic [CAP_W-1:0]     cap_lim;
  logic [CAP_W-1:0]     cap_eff;
  logic [31:0]          bsize;
  logic [6:0]           off_bytes;
  logic [ADDR_W-1:0]    addr;
  logic [ADDR_W-1:0]    payload;
  logic [ADDR_W-1:0]    fblk;
  logic [HEAD_W-1:0]    head_sel;
  logic [31:0]          rd_lo;
  logic [31:0]          rd_hi;

  logic                 ram_en;
  logic                 ram_we;
  logic [WADDR_W-1:0]   ram_addr;
  logic [WORD_W-1:0]    ram_wdata;
  logic [WORD_W-1:0]    ram_rdata;

  assign cfg_ready = 1'b1;

  assign t_size  = {1'b0, in_req.request_size} +
                   ((in_req.request_alignment > 8'd16) ? 32'd63 : 32'd15);
  assign t_len   = bit_len(t_size);
  assign new_cls = (t_len < CNT_W'(MIN_CLASS)) ? CNT_W'(MIN_CLASS) : t_len;

  assign cap_lim   = (cap_r > CAP_W'(ARENA_BYTES)) ? CAP_W'(ARENA_BYTES) : cap_r;
  assign cap_eff   = {cap_lim[CAP_W-1:BLK_SH], {BLK_SH{1'b0}}};
  assign bsize     = 32'(1) << cls_r;
  assign off_bytes = off64_r ? 7'(BLOCK_ALIGN) : 7'd16;
  assign addr      = req_r.release_address;
  assign payload   = ADDR_W'(blk_r) + ADDR_W'(off_bytes);
  assign fblk      = addr - ADDR_W'(off_bytes);
  assign head_sel  = heads_r[cls_r];
  assign rd_lo     = ram_rdata[31:0];
  assign rd_hi     = ram_rdata[63:32];

  always_comb begin
    stat.clr_last  = (clr_r == WADDR_W'(ARENA_WORDS - 1));
    stat.is_free   = (req_r.command == CMD_FREE);
    stat.align_bad = align_bad_r;
    stat.too_large = big_r;
    stat.head_nz   = (head_sel != '0);
    stat.bump_fits = ({1'b0, 32'(bump_r)} + {1'b0, bsize}) <= 33'(cap_eff);
    stat.addr_null = (addr == '0);
    stat.addr_bad  = (addr[3:0] != 4'd0) || (addr >= cap_eff);
    stat.magic_ok  = (rd_lo == HDR_MAGIC);
    stat.hdr_ok    = (rd_lo >= 32'(MIN_CLASS)) && (rd_lo < 32'(CLASS_COUNT)) &&
                     ((rd_hi == 32'd16) || (rd_hi == 32'(BLOCK_ALIGN))) &&
                     !((rd_hi == 32'(BLOCK_ALIGN)) && (addr < ADDR_W'(BLOCK_ALIGN)));
    stat.out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = '0;
    case (cmd.op)
      OP_CLEAR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = clr_r;
      end
      OP_POP_RD: begin
        ram_en   = 1'b1;
        ram_addr = word_index({1'b0, head_sel});
      end
      OP_WR_HDR0: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = word_index(payload - ADDR_W'(16));
        ram_wdata = {32'(off_bytes), 32'(cls_r)};
      end
      OP_WR_HDR1: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = word_index(payload - ADDR_W'(8));
        ram_wdata = {32'd0, HDR_MAGIC};
      end
      OP_RD_W1: begin
        ram_en   = 1'b1;
        ram_addr = word_index(addr - ADDR_W'(8));
      end
      OP_RD_W0: begin
        ram_en   = 1'b1;
        ram_addr = word_index(addr - ADDR_W'(16));
      end
      OP_FWR1: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = word_index(addr - ADDR_W'(8));
        ram_wdata = {w1hi_r, 32'd0};
      end
      OP_FWR0: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = word_index(fblk);
        ram_wdata = WORD_W'(head_sel);
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  scfl_ram #(
    .WIDTH(WORD_W),
    .DEPTH(ARENA_WORDS)
  ) u_arena (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      bump_r      <= CAP_W'(BUMP_BASE);
      live_r      <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CLASS_COUNT; i++) begin
        heads_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      case (cmd.op)
        OP_CLEAR:   clr_r <= clr_r + WADDR_W'(1);
        OP_POP_UPD: heads_r[cls_r] <= ram_rdata[HEAD_W-1:0];
        OP_BUMP:    bump_r <= bump_r + bsize[CAP_W-1:0];
        OP_WR_HDR1: live_r <= live_r + bsize[CAP_W-1:0];
        OP_FWR0: begin
          heads_r[cls_r] <= fblk[HEAD_W-1:0];
          live_r <= (32'(live_r) >= bsize) ? (live_r - bsize[CAP_W-1:0]) : '0;
        end
        default: begin
          clr_r <= clr_r;
        end
      endcase
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        req_r       <= in_req;
        cls_r       <= new_cls[CLS_W-1:0];
        big_r       <= ({1'b0, new_cls} >= (CNT_W + 1)'(CLASS_COUNT));
        off64_r     <= (in_req.request_alignment > 8'd16);
        align_bad_r <= (in_req.request_alignment > ALIGN_W'(BLOCK_ALIGN));
      end
      OP_POP_RD:    blk_r <= head_sel;
      OP_BUMP:      blk_r <= bump_r[HEAD_W-1:0];
      OP_RD_W0:     w1hi_r <= rd_hi;
      OP_LATCH_HDR: begin
        cls_r   <= rd_lo[CLS_W-1:0];
        off64_r <= (rd_hi == 32'(BLOCK_ALIGN));
      end
      default: begin
        blk_r <= blk_r;
      end
    endcase
    if (cmd.out_load) begin
      rsp_r.status          <= cmd.status;
      rsp_r.payload_address <= cmd.give_addr ? payload[PAY_W-1:0] : '0;
      rsp_r.live_bytes      <= live_r;
      rsp_r.used_bytes      <= bump_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

  a_bump_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (bump_r >= $past(bump_r)) && (bump_r[BLK_SH-1:0] == '0))
    else $error("bump pointer shrank or lost block alignment");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_POP_RD) |=> (blk_r != '0))
    else $error("popped an empty class list");

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CAP_W'(ARENA_BYTES))
    else $error("live byte count exceeds the arena");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result register loaded while a result is still held");

endmodule

### sv/scfl_ctrl.sv
// Controller state machine that sequences the arena clear and each allocate or free request.
module scfl_ctrl import scfl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  scfl_stat_t stat,
  output scfl_cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PLAN  = 4'd2;
  localparam logic [3:0] S_POP   = 4'd3;
  localparam logic [3:0] S_WR0   = 4'd4;
  localparam logic [3:0] S_WR1   = 4'd5;
  localparam logic [3:0] S_FRD1  = 4'd6;
  localparam logic [3:0] S_FRD0  = 4'd7;
  localparam logic [3:0] S_FWR1  = 4'd8;
  localparam logic [3:0] S_FWR0  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0]      state_r;
  logic [3:0]      state_nxt;
  logic [ST_W-1:0] status_r;
  logic [ST_W-1:0] status_nxt;
  logic            give_r;
  logic            give_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    give_nxt      = give_r;
    cmd.op        = OP_NONE;
    cmd.out_load  = 1'b0;
    cmd.status    = status_r;
    cmd.give_addr = give_r;
    case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = S_PLAN;
        end
      end
      S_PLAN: begin
        give_nxt = 1'b0;
        if (!stat.is_free) begin
          if (stat.align_bad) begin
            status_nxt = ST_BAD_ALIGN;
            state_nxt  = S_FIN;
          end else if (stat.too_large) begin
            status_nxt = ST_TOO_LARGE;
            state_nxt  = S_FIN;
          end else if (stat.head_nz) begin
            cmd.op    = OP_POP_RD;
            state_nxt = S_POP;
          end else if (stat.bump_fits) begin
            cmd.op    = OP_BUMP;
            state_nxt = S_WR0;
          end else begin
            status_nxt = ST_EXHAUSTED;
            state_nxt  = S_FIN;
          end
        end else if (stat.addr_null) begin
          status_nxt = ST_OK;
          state_nxt  = S_FIN;
        end else if (stat.addr_bad) begin
          status_nxt = ST_FOREIGN;
          state_nxt  = S_FIN;
        end else begin
          cmd.op    = OP_RD_W1;
          state_nxt = S_FRD1;
        end
      end
      S_POP: begin
        cmd.op    = OP_POP_UPD;
        state_nxt = S_WR0;
      end
      S_WR0: begin
        cmd.op    = OP_WR_HDR0;
        state_nxt = S_WR1;
      end
      S_WR1: begin
        cmd.op     = OP_WR_HDR1;
        status_nxt = ST_OK;
        give_nxt   = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FRD1: begin
        if (stat.magic_ok) begin
          cmd.op    = OP_RD_W0;
          state_nxt = S_FRD0;
        end else begin
          status_nxt = ST_CORRUPT;
          state_nxt  = S_FIN;
        end
      end
      S_FRD0: begin
        cmd.op = OP_LATCH_HDR;
        if (stat.hdr_ok) begin
          state_nxt = S_FWR1;
        end else begin
          status_nxt = ST_CORRUPT;
          state_nxt  = S_FIN;
        end
      end
      S_FWR1: begin
        cmd.op    = OP_FWR1;
        state_nxt = S_FWR0;
      end
      S_FWR0: begin
        cmd.op     = OP_FWR0;
        status_nxt = ST_OK;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      status_r <= ST_OK;
      give_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      give_r   <= give_nxt;
    end
  end

endmodule
